FILE: hdl/sgr_pen_attribute_decoder_assert.svh
// Assertion macros shared by the pen attribute decoder modules.
`ifndef SGR_PEN_ATTRIBUTE_DECODER_ASSERT_SVH
`define SGR_PEN_ATTRIBUTE_DECODER_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define SGR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgr check failed in the same cycle");

// Checks that a condition implies another in the following cycle.
`define SGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgr check failed in the following cycle");

`endif

FILE: hdl/sgr_pkg.sv
// Package with the types and code constants of the pen attribute decoder.
`timescale 1ns / 1ps
package sgr_pkg;

	// Colour kinds.
	localparam logic [1:0] KindDefault = 2'd0;
	localparam logic [1:0] KindPalette = 2'd1;
	localparam logic [1:0] KindRgb     = 2'd2;

	// Control codes and colour range bases.
	localparam logic [15:0] SgrReset     = 16'd0;
	localparam logic [15:0] SgrStyleLo   = 16'd1;
	localparam logic [15:0] SgrStyleHi   = 16'd9;
	localparam logic [15:0] SgrClearLo   = 16'd21;
	localparam logic [15:0] SgrClearHi   = 16'd29;
	localparam logic [15:0] SgrFgBase    = 16'd30;
	localparam logic [15:0] SgrBgBase    = 16'd40;
	localparam logic [15:0] SgrFgBright  = 16'd90;
	localparam logic [15:0] SgrBgBright  = 16'd100;
	localparam logic [15:0] SgrFgExt     = 16'd38;
	localparam logic [15:0] SgrBgExt     = 16'd48;
	localparam logic [15:0] SgrFgDefault = 16'd39;
	localparam logic [15:0] SgrBgDefault = 16'd49;
	localparam logic [15:0] SubPalette   = 16'd5;
	localparam logic [15:0] SubRgb       = 16'd2;
	localparam logic [15:0] ColourSpan   = 16'd7;
	localparam logic [7:0]  BrightOffset = 8'd8;

	// Style flag positions.
	localparam int StyleBold      = 0;
	localparam int StyleDim       = 1;
	localparam int StyleItalic    = 2;
	localparam int StyleUnderline = 3;
	localparam int StyleBlink     = 4;
	localparam int StyleInverse   = 5;
	localparam int StyleStrike    = 6;

	// Visible pen state.
	typedef struct packed {
		logic [1:0]  fg_kind;
		logic [23:0] fg_value;
		logic [1:0]  bg_kind;
		logic [23:0] bg_value;
		logic [6:0]  style_flags;
	} pen_t;

	// One result word: the pen after an item and its changed bit.
	typedef struct packed {
		pen_t pen;
		logic changed;
	} result_t;

endpackage

FILE: hdl/sgr_ifs.sv
// Channel interfaces for SGR parameter words and pen result words.
`timescale 1ns / 1ps

interface sgr_param_if;
	logic        valid;
	logic        ready;
	logic [15:0] param_value;
	logic [4:0]  params_after;

	modport source (output valid, output param_value, output params_after, input ready);
	modport sink (input valid, input param_value, input params_after, output ready);
endinterface

interface sgr_pen_if;
	logic        valid;
	logic        ready;
	logic [1:0]  fg_kind;
	logic [23:0] fg_value;
	logic [1:0]  bg_kind;
	logic [23:0] bg_value;
	logic [6:0]  style_flags;
	logic        changed;

	modport source (output valid, output fg_kind, output fg_value, output bg_kind,
		output bg_value, output style_flags, output changed, input ready);
	modport sink (input valid, input fg_kind, input fg_value, input bg_kind,
		input bg_value, input style_flags, input changed, output ready);
endinterface

FILE: hdl/sgr_pen_core.sv
// Pen state and extended colour tracking, with the decode of one parameter.
`timescale 1ns / 1ps
`include "sgr_pen_attribute_decoder_assert.svh"

module sgr_pen_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [15:0]     param_value,
	input  logic [4:0]      params_after,
	output sgr_pkg::result_t result
);
	import sgr_pkg::*;

	typedef enum logic [2:0] {
		PhIdle  = 3'd0,
		PhSub   = 3'd1,
		PhIndex = 3'd2,
		PhRed   = 3'd3,
		PhGreen = 3'd4,
		PhBlue  = 3'd5
	} phase_t;

	pen_t       pen_q, pen_d, pen_base;
	phase_t     phase_q, phase_d;
	logic       to_back_q, to_back_d;
	logic [7:0] red_q, red_d, green_q, green_d;
	logic       do_decode, sub_fallback, dec_changed;
	logic [7:0] byte_val;
	logic [23:0] ext_value;

	assign byte_val = param_value[7:0];

	// Work out which path this parameter takes from the extended phase.
	always_comb begin
		do_decode    = 1'b0;
		sub_fallback = 1'b0;
		case (phase_q)
			PhSub: begin
				if (!(param_value == SubPalette && params_after != 5'd0) &&
						!(param_value == SubRgb && params_after >= 5'd3)) begin
					sub_fallback = 1'b1;
					do_decode    = 1'b1;
				end
			end
			PhIndex, PhRed, PhGreen, PhBlue: do_decode = 1'b0;
			default: do_decode = 1'b1;
		endcase
	end

	// A failed subtype first restores the target colour to default.
	always_comb begin
		pen_base = pen_q;
		if (sub_fallback) begin
			if (to_back_q) begin
				pen_base.bg_kind  = KindDefault;
				pen_base.bg_value = '0;
			end else begin
				pen_base.fg_kind  = KindDefault;
				pen_base.fg_value = '0;
			end
		end
	end

	assign ext_value = (phase_q == PhBlue) ? {red_q, green_q, byte_val} : {16'd0, byte_val};

	// Next state of the pen and of the extended colour tracker.
	always_comb begin
		pen_d       = pen_base;
		phase_d     = PhIdle;
		to_back_d   = to_back_q;
		red_d       = red_q;
		green_d     = green_q;
		dec_changed = 1'b0;
		if (do_decode) begin
			if (param_value == SgrReset) begin
				pen_d       = '0;
				dec_changed = 1'b1;
			end else if (param_value >= SgrStyleLo && param_value <= SgrStyleHi) begin
				dec_changed = 1'b1;
				case (param_value[3:0])
					4'd1: pen_d.style_flags[StyleBold]      = 1'b1;
					4'd2: pen_d.style_flags[StyleDim]       = 1'b1;
					4'd3: pen_d.style_flags[StyleItalic]    = 1'b1;
					4'd4: pen_d.style_flags[StyleUnderline] = 1'b1;
					4'd5, 4'd6: pen_d.style_flags[StyleBlink] = 1'b1;
					4'd7: pen_d.style_flags[StyleInverse]   = 1'b1;
					4'd9: pen_d.style_flags[StyleStrike]    = 1'b1;
					default: pen_d.style_flags = pen_base.style_flags;
				endcase
			end else if (param_value >= SgrClearLo && param_value <= SgrClearHi) begin
				dec_changed = 1'b1;
				case (param_value[4:0])
					5'd21, 5'd22: begin
						pen_d.style_flags[StyleBold] = 1'b0;
						pen_d.style_flags[StyleDim]  = 1'b0;
					end
					5'd23: pen_d.style_flags[StyleItalic]    = 1'b0;
					5'd24: pen_d.style_flags[StyleUnderline] = 1'b0;
					5'd25: pen_d.style_flags[StyleBlink]     = 1'b0;
					5'd27: pen_d.style_flags[StyleInverse]   = 1'b0;
					5'd29: pen_d.style_flags[StyleStrike]    = 1'b0;
					default: pen_d.style_flags = pen_base.style_flags;
				endcase
			end else if (param_value >= SgrFgBase && param_value <= SgrFgBase + ColourSpan) begin
				dec_changed    = 1'b1;
				pen_d.fg_kind  = KindPalette;
				pen_d.fg_value = {16'd0, byte_val - SgrFgBase[7:0]};
			end else if (param_value >= SgrBgBase && param_value <= SgrBgBase + ColourSpan) begin
				dec_changed    = 1'b1;
				pen_d.bg_kind  = KindPalette;
				pen_d.bg_value = {16'd0, byte_val - SgrBgBase[7:0]};
			end else if (param_value >= SgrFgBright &&
					param_value <= SgrFgBright + ColourSpan) begin
				dec_changed    = 1'b1;
				pen_d.fg_kind  = KindPalette;
				pen_d.fg_value = {16'd0, byte_val - SgrFgBright[7:0] + BrightOffset};
			end else if (param_value >= SgrBgBright &&
					param_value <= SgrBgBright + ColourSpan) begin
				dec_changed    = 1'b1;
				pen_d.bg_kind  = KindPalette;
				pen_d.bg_value = {16'd0, byte_val - SgrBgBright[7:0] + BrightOffset};
			end else if (param_value == SgrFgDefault) begin
				dec_changed    = 1'b1;
				pen_d.fg_kind  = KindDefault;
				pen_d.fg_value = '0;
			end else if (param_value == SgrBgDefault) begin
				dec_changed    = 1'b1;
				pen_d.bg_kind  = KindDefault;
				pen_d.bg_value = '0;
			end else if (param_value == SgrFgExt || param_value == SgrBgExt) begin
				if (params_after == 5'd0) begin
					dec_changed = 1'b1;
					if (param_value == SgrBgExt) begin
						pen_d.bg_kind  = KindDefault;
						pen_d.bg_value = '0;
					end else begin
						pen_d.fg_kind  = KindDefault;
						pen_d.fg_value = '0;
					end
				end else begin
					to_back_d = (param_value == SgrBgExt);
					phase_d   = PhSub;
				end
			end
		end else begin
			case (phase_q)
				PhSub: phase_d = (param_value == SubPalette) ? PhIndex : PhRed;
				PhRed: begin
					red_d   = byte_val;
					phase_d = PhGreen;
				end
				PhGreen: begin
					green_d = byte_val;
					phase_d = PhBlue;
				end
				PhIndex, PhBlue: begin
					if (to_back_q) begin
						pen_d.bg_kind  = (phase_q == PhBlue) ? KindRgb : KindPalette;
						pen_d.bg_value = ext_value;
					end else begin
						pen_d.fg_kind  = (phase_q == PhBlue) ? KindRgb : KindPalette;
						pen_d.fg_value = ext_value;
					end
				end
				default: phase_d = PhIdle;
			endcase
		end
	end

	// The result carries the updated pen of this parameter.
	assign result.pen     = pen_d;
	assign result.changed = sub_fallback | dec_changed |
		(!do_decode && (phase_q == PhIndex || phase_q == PhBlue));

	// State registers advance once per processed parameter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q     <= '0;
			phase_q   <= PhIdle;
			to_back_q <= 1'b0;
			red_q     <= '0;
			green_q   <= '0;
		end else if (step) begin
			pen_q     <= pen_d;
			phase_q   <= phase_d;
			to_back_q <= to_back_d;
			red_q     <= red_d;
			green_q   <= green_d;
		end
	end

	`SGR_ASSERT_SAME(a_fg_default_zero, clk, arst_n, pen_q.fg_kind == KindDefault,
		pen_q.fg_value == 24'd0)
	`SGR_ASSERT_SAME(a_bg_palette_narrow, clk, arst_n, pen_q.bg_kind == KindPalette,
		pen_q.bg_value[23:8] == 16'd0)
	`SGR_ASSERT_NEXT(a_red_then_green, clk, arst_n, step && phase_q == PhRed,
		phase_q == PhGreen)
endmodule

FILE: hdl/sgr_pen_attribute_decoder.sv
// Top level of the SGR pen attribute decoder: handshake stages around the pen core.
`timescale 1ns / 1ps
`include "sgr_pen_attribute_decoder_assert.svh"

// One SGR parameter word in gives one pen word out, one word per cycle when
// neither side stalls. A word waits in the input register, where the pen
// core decodes it against the stored pen and extended colour phase, and
// then sits in the result register until taken. The pen state updates when
// a word moves from the input to the result register, so the next word
// always sees the effect of the one before it.
module sgr_pen_attribute_decoder (
	input  logic   clk,
	input  logic   arst_n,
	sgr_param_if.sink sgr,
	sgr_pen_if.source pen
);
	import sgr_pkg::*;

	logic        valid_s1;
	logic [15:0] value_s1;
	logic [4:0]  after_s1;
	logic        valid_s2;
	result_t     result_s2;
	result_t     result_next;
	logic        step;

	// A word advances when the result register is empty or being emptied.
	assign step      = valid_s1 && (!valid_s2 || pen.ready);
	assign sgr.ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sgr.ready) begin
			valid_s1 <= sgr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sgr.ready && sgr.valid) begin
			value_s1 <= sgr.param_value;
			after_s1 <= sgr.params_after;
		end
	end

	sgr_pen_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.param_value  (value_s1),
		.params_after (after_s1),
		.result       (result_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (pen.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result_next;
		end
	end

	assign pen.valid       = valid_s2;
	assign pen.fg_kind     = result_s2.pen.fg_kind;
	assign pen.fg_value    = result_s2.pen.fg_value;
	assign pen.bg_kind     = result_s2.pen.bg_kind;
	assign pen.bg_value    = result_s2.pen.bg_value;
	assign pen.style_flags = result_s2.pen.style_flags;
	assign pen.changed     = result_s2.changed;

	`SGR_ASSERT_SAME(a_stall_reason, clk, arst_n, !sgr.ready,
		valid_s1 && valid_s2 && !pen.ready)
	`SGR_ASSERT_NEXT(a_step_fills_out, clk, arst_n, step, valid_s2)
	`SGR_ASSERT_SAME(a_kind_legal, clk, arst_n, valid_s2,
		pen.fg_kind <= KindRgb && pen.bg_kind <= KindRgb)
endmodule
